/* rtl/mcot_pkg.sv */
package mcot_pkg;

  localparam int unsigned CHANNELS = 8;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned CH_W   = 4;
  localparam int unsigned DUR_W  = 31;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_e;

  localparam logic EV_EXPIRY  = 1'b0;
  localparam logic EV_SUMMARY = 1'b1;

  // one timer channel as held in a cell
  typedef struct packed {
    logic             armed;
    logic [CNT_W-1:0] deadline;
  } chan_t;

  // per-cell control
  typedef struct packed {
    logic shift;  // take the neighbor's contents
    logic set;    // arm with a new deadline
    logic clr;    // disarm
  } cell_ctrl_t;

endpackage

/* rtl/multi_channel_oneshot_timer_unit.sv */
// Bank of CHANNELS one-shot timers sharing a 32-bit tick count.
// An input transaction is a tick (count + 1), a start (arm channel with
// deadline = count + duration) or a stop (disarm channel); start/stop on a
// channel at or above CHANNELS, and kind 3, change nothing. After each
// transaction every armed channel whose deadline is <= count (plain unsigned
// compare) fires in ascending order: one expiry result each, then a summary
// result (last = 1) with any_armed and the ticks to the earliest remaining
// deadline. Channels live in a ring of cells that rotates by one position per
// cycle past a single head compare unit, except while a fire waits for a full,
// stalled output register; the summary likewise waits for it. A transaction is
// accepted and its operation applied, then the ring rotates once through the
// head, then the summary is issued. The next transaction is accepted once the
// summary has moved into the output register.
module multi_channel_oneshot_timer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mcot_pkg::KIND_W-1:0]   kind_i,
  input  logic [mcot_pkg::CH_W-1:0]     channel_i,
  input  logic [mcot_pkg::DUR_W-1:0]    duration_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          event_res_o,
  output logic [mcot_pkg::CH_W-1:0]     fired_channel_o,
  output logic                          any_armed_o,
  output logic [mcot_pkg::CNT_W-1:0]    wait_ticks_o,
  output logic                          last_o
);

  localparam int unsigned N = mcot_pkg::CHANNELS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_SUM  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [mcot_pkg::CNT_W-1:0] tick_count_q, tick_count_d;
  logic [mcot_pkg::IDX_W-1:0] scan_q, scan_d;      // channel now at the head
  logic                       any_q, any_d;        // running min valid
  logic [mcot_pkg::CNT_W-1:0] best_q, best_d;      // running min deadline

  // output register
  logic                       out_valid_q, out_valid_d;
  logic                       ev_q, ev_d;
  logic [mcot_pkg::CH_W-1:0]  ch_q, ch_d;
  logic                       anyo_q, anyo_d;
  logic [mcot_pkg::CNT_W-1:0] wait_q, wait_d;
  logic                       last_q, last_d;

  mcot_pkg::chan_t      cell_state [N];
  mcot_pkg::chan_t      cell_nbr   [N];
  mcot_pkg::cell_ctrl_t cell_ctrl  [N];

  logic                       in_accept;
  logic                       out_free;
  logic                       chan_ok;
  logic                       head_fire;
  logic                       shift;
  logic [mcot_pkg::CNT_W-1:0] new_deadline;
  mcot_pkg::chan_t            head_pass;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign chan_ok      = ({1'b0, channel_i} < (mcot_pkg::CH_W + 1)'(N));
  assign new_deadline = tick_count_q + {1'b0, duration_i};

  // head compare: cell 0 holds channel scan_q
  assign head_fire = cell_state[0].armed && (cell_state[0].deadline <= tick_count_q);
  // ring rotates unless a fire must wait for the output register
  assign shift     = (state_q == ST_SCAN) && (!head_fire || out_free);

  // head re-enters at the tail, disarmed if it fired
  assign head_pass.armed    = cell_state[0].armed && !head_fire;
  assign head_pass.deadline = cell_state[0].deadline;

  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam int unsigned NEXT = (k + 1) % N;

    logic sel;
    assign sel = in_accept && chan_ok && (channel_i == mcot_pkg::CH_W'(k));

    assign cell_nbr[k] = (k == N - 1) ? head_pass : cell_state[NEXT];

    assign cell_ctrl[k].shift = shift;
    assign cell_ctrl[k].set   = sel && (mcot_pkg::kind_e'(kind_i) == mcot_pkg::KIND_START);
    assign cell_ctrl[k].clr   = sel && (mcot_pkg::kind_e'(kind_i) == mcot_pkg::KIND_STOP);

    mcot_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl[k]),
      .neighbor_i (cell_nbr[k]),
      .deadline_i (new_deadline),
      .state_o    (cell_state[k])
    );
  end

  always_comb begin
    state_d      = state_q;
    tick_count_d = tick_count_q;
    scan_d       = scan_q;
    any_d        = any_q;
    best_d       = best_q;

    out_valid_d  = out_valid_q && out_stall_i;
    ev_d         = ev_q;
    ch_d         = ch_q;
    anyo_d       = anyo_q;
    wait_d       = wait_q;
    last_d       = last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (mcot_pkg::kind_e'(kind_i))
            mcot_pkg::KIND_TICK: tick_count_d = tick_count_q + 1'b1;
            default: ;  // start/stop act on the cells; kind 3 does nothing
          endcase
          scan_d  = '0;
          any_d   = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (shift) begin
          if (head_fire) begin
            out_valid_d = 1'b1;
            ev_d        = mcot_pkg::EV_EXPIRY;
            ch_d        = mcot_pkg::CH_W'(scan_q);
            anyo_d      = 1'b0;
            wait_d      = '0;
            last_d      = 1'b0;
          end else if (cell_state[0].armed) begin
            any_d = 1'b1;
            if (!any_q || (cell_state[0].deadline < best_q)) begin
              best_d = cell_state[0].deadline;
            end
          end
          if (scan_q == mcot_pkg::IDX_W'(N - 1)) begin
            state_d = ST_SUM;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end
      end
      ST_SUM: begin
        if (out_free) begin
          // remaining armed deadlines all lie above the count
          out_valid_d = 1'b1;
          ev_d        = mcot_pkg::EV_SUMMARY;
          ch_d        = '0;
          anyo_d      = any_q;
          wait_d      = any_q ? (best_q - tick_count_q) : '0;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tick_count_q <= '0;
      scan_q       <= '0;
      any_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      tick_count_q <= tick_count_d;
      scan_q       <= scan_d;
      any_q        <= any_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    ev_q   <= ev_d;
    ch_q   <= ch_d;
    anyo_q <= anyo_d;
    wait_q <= wait_d;
    last_q <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = ev_q;
  assign fired_channel_o = ch_q;
  assign any_armed_o     = anyo_q;
  assign wait_ticks_o    = wait_q;
  assign last_o          = last_q;

  // accepted transaction always starts a ring pass
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_SCAN) && (scan_q == '0))
    else $error("accepted transaction did not start a scan");

  // only the summary carries last
  a_last_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (event_res_o == mcot_pkg::EV_SUMMARY)))
    else $error("last flag disagrees with result kind");

  // while idle the pending result, if any, is the summary
  a_idle_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && out_valid_o |-> last_o)
    else $error("expiry pending while idle");

  // expiries name an existing channel
  a_fired_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == mcot_pkg::EV_EXPIRY) |->
      ({1'b0, fired_channel_o} < (mcot_pkg::CH_W + 1)'(N)))
    else $error("expiry for nonexistent channel");

  // a summary with armed channels never reports zero wait
  a_wait_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && any_armed_o |-> (wait_ticks_o != '0))
    else $error("armed summary with zero wait");

endmodule

/* rtl/mcot_cell.sv */
module mcot_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mcot_pkg::cell_ctrl_t           ctrl_i,
  input  mcot_pkg::chan_t                neighbor_i,
  input  logic [mcot_pkg::CNT_W-1:0]     deadline_i,
  output mcot_pkg::chan_t                state_o
);

  logic                       armed_q, armed_d;
  logic [mcot_pkg::CNT_W-1:0] deadline_q, deadline_d;

  always_comb begin
    armed_d    = armed_q;
    deadline_d = deadline_q;
    if (ctrl_i.shift) begin
      armed_d    = neighbor_i.armed;
      deadline_d = neighbor_i.deadline;
    end else if (ctrl_i.set) begin
      armed_d    = 1'b1;
      deadline_d = deadline_i;
    end else if (ctrl_i.clr) begin
      armed_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
    end else begin
      armed_q <= armed_d;
    end
  end

  // deadline is payload, meaningful only while armed
  always_ff @(posedge clk_i) begin
    deadline_q <= deadline_d;
  end

  assign state_o.armed    = armed_q;
  assign state_o.deadline = deadline_q;

endmodule
